// File: rtl/kvt_pkg.sv
// Shared codes, command and status types for the key-value table engine.
package kvt_pkg;

   localparam int KEY_IN_W   = 32;
   localparam int VALUE_IN_W = 32;
   localparam int POS_W      = 4;
   localparam int TOTAL_W    = 5;

   localparam logic [2:0] MODE_INSERT   = 3'd0;
   localparam logic [2:0] MODE_UPDATE   = 3'd1;
   localparam logic [2:0] MODE_UPSERT   = 3'd2;
   localparam logic [2:0] MODE_ERASE    = 3'd3;
   localparam logic [2:0] MODE_CONTAINS = 3'd4;
   localparam logic [2:0] MODE_LOOKUP   = 3'd5;
   localparam logic [2:0] MODE_READ     = 3'd6;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_KEY_FAIL  = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_POS_RANGE = 2'd3;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SEARCH,
      CMD_SETUP_UP,
      CMD_SHIFT_UP,
      CMD_FRONT,
      CMD_SETUP_DOWN,
      CMD_SHIFT_DOWN,
      CMD_WRVAL,
      CMD_READ,
      CMD_CAPTURE,
      CMD_FINISH
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       set_status;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       found;
      logic       full;
      logic       pos_ok;
      logic       srch_done;
      logic       shift_done;
      logic       out_free;
   } stat_type;

endpackage

// File: rtl/kvt_ifs.sv
// Request and response channel interfaces of the key-value table engine.
interface kvt_req_if import kvt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [2:0]            mode;
   logic [KEY_IN_W-1:0]   key;
   logic [VALUE_IN_W-1:0] value;
   logic [POS_W-1:0]      position;

   modport source (output valid, mode, key, value, position, input ready);
   modport sink   (input valid, mode, key, value, position, output ready);
endinterface

interface kvt_rsp_if import kvt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [KEY_IN_W-1:0]   found_key;
   logic [VALUE_IN_W-1:0] found_value;
   logic [TOTAL_W-1:0]    entry_total;

   modport source (output valid, status, found_key, found_value, entry_total, input ready);
   modport sink   (input valid, status, found_key, found_value, entry_total, output ready);
endinterface

// File: rtl/kvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/kvt_ctrl.sv
// Controller state machine sequencing search, shift, access and result steps.
module kvt_ctrl import kvt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_SEARCH     = 4'd1;
   localparam logic [3:0] S_DECIDE     = 4'd2;
   localparam logic [3:0] S_SHIFT_UP   = 4'd3;
   localparam logic [3:0] S_FRONT      = 4'd4;
   localparam logic [3:0] S_SHIFT_DOWN = 4'd5;
   localparam logic [3:0] S_WRVAL      = 4'd6;
   localparam logic [3:0] S_READ       = 4'd7;
   localparam logic [3:0] S_CAPTURE    = 4'd8;
   localparam logic [3:0] S_FINISH     = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.op         = CMD_NONE;
      cmd.set_status = 1'b0;
      cmd.status     = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = CMD_LOAD;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (stat.mode > MODE_LOOKUP) begin
               state_in = S_DECIDE;
            end else begin
               cmd.op = CMD_SEARCH;
               if (stat.srch_done) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            state_in = S_FINISH;
            unique case (stat.mode)
               MODE_INSERT, MODE_UPSERT: begin
                  if (stat.found && stat.mode == MODE_INSERT) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_KEY_FAIL;
                  end else if (stat.found) begin
                     state_in = S_WRVAL;
                  end else if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.op   = CMD_SETUP_UP;
                     state_in = S_SHIFT_UP;
                  end
               end
               MODE_UPDATE: begin
                  if (stat.found) begin
                     state_in = S_WRVAL;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_KEY_FAIL;
                  end
               end
               MODE_ERASE: begin
                  if (stat.found) begin
                     cmd.op   = CMD_SETUP_DOWN;
                     state_in = S_SHIFT_DOWN;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_KEY_FAIL;
                  end
               end
               MODE_CONTAINS: begin
                  if (!stat.found) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_KEY_FAIL;
                  end
               end
               MODE_LOOKUP: begin
                  if (stat.found) begin
                     state_in = S_READ;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_KEY_FAIL;
                  end
               end
               MODE_READ: begin
                  if (stat.pos_ok) begin
                     state_in = S_READ;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_POS_RANGE;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SHIFT_UP: begin
            cmd.op = CMD_SHIFT_UP;
            if (stat.shift_done) begin
               state_in = S_FRONT;
            end
         end
         S_FRONT: begin
            cmd.op   = CMD_FRONT;
            state_in = S_FINISH;
         end
         S_SHIFT_DOWN: begin
            cmd.op = CMD_SHIFT_DOWN;
            if (stat.shift_done) begin
               state_in = S_FINISH;
            end
         end
         S_WRVAL: begin
            cmd.op   = CMD_WRVAL;
            state_in = S_FINISH;
         end
         S_READ: begin
            cmd.op   = CMD_READ;
            state_in = S_CAPTURE;
         end
         S_CAPTURE: begin
            cmd.op   = CMD_CAPTURE;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.op   = CMD_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/kvt_datapath.sv
// Datapath: request registers, entry RAMs, scan counter, count and result register.
module kvt_datapath import kvt_pkg::*; #(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [2:0]            req_mode,
   input  logic [KEY_IN_W-1:0]   req_key,
   input  logic [VALUE_IN_W-1:0] req_value,
   input  logic [POS_W-1:0]      req_position,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [KEY_IN_W-1:0]   rsp_found_key,
   output logic [VALUE_IN_W-1:0] rsp_found_value,
   output logic [TOTAL_W-1:0]    rsp_entry_total
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
   localparam int VW = (VALUE_BITS < VALUE_IN_W) ? VALUE_BITS : VALUE_IN_W;

   logic [2:0]         mode_ff, mode_in;
   logic [KW-1:0]      key_ff, key_in;
   logic [VW-1:0]      val_ff, val_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic               found_ff, found_in;
   logic [AW-1:0]      at_ff, at_in;
   logic [1:0]         status_ff, status_in;
   logic [KW-1:0]      fkey_ff, fkey_in;
   logic [VW-1:0]      fval_ff, fval_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [KW-1:0]      rsp_key_ff, rsp_key_in;
   logic [VW-1:0]      rsp_val_ff, rsp_val_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic          key_wr_en, val_wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [KW-1:0] key_wdata, key_rd;
   logic [VW-1:0] val_wdata, val_rd;
   logic          issue, hit, up_done, down_done;
   logic [CW-1:0] scan_dec;

   kvt_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_wdata),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   kvt_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_wdata),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   assign issue     = scan_ff < count_ff;
   assign hit       = pend_ff && (key_rd == key_ff);
   assign scan_dec  = scan_ff - 1'b1;
   assign up_done   = !pend_ff && (scan_ff == '0);
   assign down_done = !pend_ff && !issue;

   assign stat.mode       = mode_ff;
   assign stat.found      = found_ff;
   assign stat.full       = count_ff == CW'(CAPACITY);
   assign stat.pos_ok     = 32'(pos_ff) < 32'(count_ff);
   assign stat.srch_done  = hit || (!pend_ff && !issue);
   assign stat.shift_done = (mode_ff == MODE_ERASE) ? down_done : up_done;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mode_in       = mode_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      found_in      = found_ff;
      at_in         = at_ff;
      status_in     = status_ff;
      fkey_in       = fkey_ff;
      fval_in       = fval_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_total_in  = rsp_total_ff;
      key_wr_en     = 1'b0;
      val_wr_en     = 1'b0;
      wr_addr       = pend_addr_ff;
      rd_addr       = scan_ff[AW-1:0];
      key_wdata     = key_rd;
      val_wdata     = val_rd;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (cmd.op)
         CMD_LOAD: begin
            mode_in   = req_mode;
            key_in    = req_key[KW-1:0];
            val_in    = req_value[VW-1:0];
            pos_in    = req_position;
            scan_in   = '0;
            pend_in   = 1'b0;
            found_in  = 1'b0;
            status_in = ST_OK;
            fkey_in   = '0;
            fval_in   = '0;
         end
         CMD_SEARCH: begin
            pend_in      = issue;
            pend_addr_in = scan_ff[AW-1:0];
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (hit) begin
               found_in = 1'b1;
               at_in    = pend_addr_ff;
            end
         end
         CMD_SETUP_UP: begin
            scan_in = count_ff;
            pend_in = 1'b0;
         end
         CMD_SHIFT_UP: begin
            rd_addr      = scan_dec[AW-1:0];
            pend_in      = scan_ff != '0;
            pend_addr_in = scan_dec[AW-1:0];
            if (scan_ff != '0) begin
               scan_in = scan_dec;
            end
            if (pend_ff) begin
               key_wr_en = 1'b1;
               val_wr_en = 1'b1;
               wr_addr   = pend_addr_ff + 1'b1;
            end
         end
         CMD_FRONT: begin
            key_wr_en = 1'b1;
            val_wr_en = 1'b1;
            wr_addr   = '0;
            key_wdata = key_ff;
            val_wdata = val_ff;
            count_in  = count_ff + 1'b1;
         end
         CMD_SETUP_DOWN: begin
            scan_in = CW'(at_ff) + 1'b1;
            pend_in = 1'b0;
         end
         CMD_SHIFT_DOWN: begin
            pend_in      = issue;
            pend_addr_in = scan_ff[AW-1:0];
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (pend_ff) begin
               key_wr_en = 1'b1;
               val_wr_en = 1'b1;
               wr_addr   = pend_addr_ff - 1'b1;
            end
            if (down_done) begin
               count_in = count_ff - 1'b1;
            end
         end
         CMD_WRVAL: begin
            val_wr_en = 1'b1;
            wr_addr   = at_ff;
            val_wdata = val_ff;
         end
         CMD_READ: begin
            rd_addr = (mode_ff == MODE_READ) ? AW'(pos_ff) : at_ff;
         end
         CMD_CAPTURE: begin
            fval_in = val_rd;
            if (mode_ff == MODE_READ) begin
               fkey_in = key_rd;
            end
         end
         CMD_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_key_in    = fkey_ff;
            rsp_val_in    = fval_ff;
            rsp_total_in  = TOTAL_W'(count_ff);
         end
         default: begin
         end
      endcase

      if (cmd.set_status) begin
         status_in = cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      scan_ff       <= scan_in;
      pend_addr_ff  <= pend_addr_in;
      found_ff      <= found_in;
      at_ff         <= at_in;
      status_ff     <= status_in;
      fkey_ff       <= fkey_in;
      fval_ff       <= fval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_key   = KEY_IN_W'(rsp_key_ff);
   assign rsp_found_value = VALUE_IN_W'(rsp_val_ff);
   assign rsp_entry_total = rsp_total_ff;

endmodule

// File: rtl/key_value_table_engine_top.sv
// Top level of the key-value table engine: controller, datapath and checks.
//
// Usage: a request word on req_ch (valid/ready) names one operation on a table
// of up to CAPACITY unique keys kept newest first. Every request gives exactly
// one response word on rsp_ch with status, found key, found value and the
// entry count after the request.
// One request is worked on at a time. An insert of a new key searches every
// entry and then shifts all entries up one place; an erase searches to the key
// and shifts the older entries down; a key hit ends the search early, and a
// read by position skips the search. The next request is accepted once the
// controller is back in idle after loading the result register.
// The run time is set by the single read port of the key and value RAMs, which
// the search and the shift walk one entry per cycle.
// The response sits in an output register; while the receiver stalls it holds,
// and the next request is accepted and worked on until its own result is ready.
// Reset empties the table (entry count zero) and drops any pending response;
// the RAM contents are not cleared and need no clearing pass.
module key_value_table_engine_top import kvt_pkg::*; #(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   kvt_req_if.sink   req_ch,
   kvt_rsp_if.source rsp_ch
);

   cmd_type  ctl_cmd;
   stat_type dp_stat;
   logic     req_ready;

   kvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   kvt_datapath #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctl_cmd),
      .stat            (dp_stat),
      .req_mode        (req_ch.mode),
      .req_key         (req_ch.key),
      .req_value       (req_ch.value),
      .req_position    (req_ch.position),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_status      (rsp_ch.status),
      .rsp_found_key   (rsp_ch.found_key),
      .rsp_found_value (rsp_ch.found_value),
      .rsp_entry_total (rsp_ch.entry_total)
   );

   assign req_ch.ready = req_ready;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while a request is in work");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.op == CMD_FINISH) |-> dp_stat.out_free)
      else $error("result register overwritten before delivery");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_FULL) |->
         (rsp_ch.entry_total == TOTAL_W'(CAPACITY % 32)))
      else $error("table full reported with room left");

endmodule
